### sv/int_to_decimal_ascii_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the decimal ASCII converter
// Concurrent assertion wrappers, compiled out when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef INT_TO_DECIMAL_ASCII_CORE_DEFINES_SVH
`define INT_TO_DECIMAL_ASCII_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Property that must hold on every clock edge outside reset.
`define ITDA_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("itda assertion failed");
// Implication from one cycle to the next, outside reset.
`define ITDA_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("itda assertion failed");
`else
`define ITDA_ASSERT(name, prop)
`define ITDA_ASSERT_NEXT(name, ante, cons)
`endif

`endif

### sv/itda_pkg.sv
// ----------------------------------------------------------------------------
// itda_pkg
// Types, character codes and conversion helpers for the decimal converter.
// ----------------------------------------------------------------------------
package itda_pkg;

  localparam int unsigned VALUE_W        = 32;
  localparam int unsigned NUM_DIGITS     = 10;
  localparam int unsigned DD_STAGES      = 4;
  localparam int unsigned BITS_PER_STAGE = VALUE_W / DD_STAGES;

  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [3:0] DIG_MAX  = 4'd9;

  typedef logic [NUM_DIGITS-1:0][3:0] bcd_t;

  typedef struct packed {
    logic               neg;
    logic [VALUE_W-1:0] mag;
    bcd_t               bcd;
  } pipe_t;

  // One pipeline stage of shift-and-add-3 conversion: consumes the top
  // BITS_PER_STAGE bits of the magnitude.
  function automatic pipe_t dd_stage(pipe_t p);
    pipe_t r;
    r = p;
    for (int s = 0; s < BITS_PER_STAGE; s++) begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
        if (r.bcd[d] > 4'd4) begin
          r.bcd[d] = r.bcd[d] + 4'd3;
        end
      end
      r.bcd = {r.bcd[NUM_DIGITS-1][2:0], r.bcd[NUM_DIGITS-2:0], r.mag[VALUE_W-1]};
      r.mag = {r.mag[VALUE_W-2:0], 1'b0};
    end
    return r;
  endfunction

  // Position of the most significant nonzero digit, zero when all are zero.
  function automatic logic [3:0] top_digit(bcd_t b);
    logic [3:0] idx;
    idx = '0;
    for (int d = 1; d < NUM_DIGITS; d++) begin
      if (b[d] != 4'd0) begin
        idx = 4'(d);
      end
    end
    return idx;
  endfunction

endpackage

### sv/int_to_decimal_ascii_core.sv
// ----------------------------------------------------------------------------
// int_to_decimal_ascii_core
// Signed 32-bit integer to decimal ASCII text, one character per item out.
// ----------------------------------------------------------------------------
// Each accepted value leaves as a run of 1 to 11 characters: a '-' for a
// negative value, then the decimal digits most significant first with no
// leading zeros, and last_o high on the final character. Zero gives "0", and
// the most negative value gives "-2147483648". The conversion runs through a
// five-register pipeline (magnitude capture, then four shift-and-add-3 stages
// of eight bits each), and the first character of a value reaches the output
// from the serializer register that follows the last stage. The character
// serializer at the end sends one character per cycle while out_ready_i is
// high, so a value occupies the output for its whole run of characters, and
// the next value waits until that run ends. While the serializer is busy,
// the pipeline keeps accepting values until every stage is full; the
// serializer loads the next value in the same cycle as the final character of
// the current one is taken, so when the last stage holds a value, runs follow
// each other with no gap.
`include "int_to_decimal_ascii_core_defines.svh"

module int_to_decimal_ascii_core
  import itda_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      value_valid_i,
  output logic                      value_ready_o,
  input  logic signed [VALUE_W-1:0] value_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [7:0]                ascii_char_o,
  output logic                      last_o
);

  // Pipeline stage registers: stage 0 holds sign and magnitude, stages 1 to
  // DD_STAGES hold the partially converted BCD digits.
  pipe_t              stg_q [DD_STAGES+1];
  logic [DD_STAGES:0] vld_q;
  logic [DD_STAGES:0] rdy;

  // Serializer registers.
  logic       ser_v_q;
  logic       ser_sgn_q;
  logic [3:0] ser_idx_q;
  bcd_t       ser_bcd_q;

  logic out_fire;
  logic ser_rdy;
  logic char_legal;

  assign out_fire = out_valid_o && out_ready_i;

  // The serializer takes a new value when empty, or when its final character
  // leaves in this cycle.
  assign ser_rdy = !ser_v_q || (out_fire && last_o);

  // A stage moves on when it is empty or its successor moves on.
  always_comb begin
    rdy[DD_STAGES] = !vld_q[DD_STAGES] || ser_rdy;
    for (int k = DD_STAGES - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  assign value_ready_o = rdy[0];

  // Valid bits travel with the data through the stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) begin
        vld_q[0] <= value_valid_i;
      end
      for (int k = 1; k <= DD_STAGES; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // Stage payloads. The magnitude is taken as an unsigned 32-bit number, so
  // negating the most negative value yields its correct magnitude.
  always_ff @(posedge clk_i) begin
    if (rdy[0] && value_valid_i) begin
      stg_q[0].neg <= value_i[VALUE_W-1];
      stg_q[0].mag <= value_i[VALUE_W-1] ? (VALUE_W'(0) - VALUE_W'(value_i))
                                         : VALUE_W'(value_i);
      stg_q[0].bcd <= '0;
    end
    for (int k = 1; k <= DD_STAGES; k++) begin
      if (rdy[k] && vld_q[k-1]) begin
        stg_q[k] <= dd_stage(stg_q[k-1]);
      end
    end
  end

  // Serializer control. The sign goes out first, then the digits from the
  // top nonzero one down to the units.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ser_v_q   <= 1'b0;
      ser_sgn_q <= 1'b0;
      ser_idx_q <= '0;
    end else if (ser_rdy) begin
      ser_v_q <= vld_q[DD_STAGES];
      if (vld_q[DD_STAGES]) begin
        ser_sgn_q <= stg_q[DD_STAGES].neg;
        ser_idx_q <= top_digit(stg_q[DD_STAGES].bcd);
      end
    end else if (out_fire) begin
      if (ser_sgn_q) begin
        ser_sgn_q <= 1'b0;
      end else begin
        ser_idx_q <= ser_idx_q - 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ser_rdy && vld_q[DD_STAGES]) begin
      ser_bcd_q <= stg_q[DD_STAGES].bcd;
    end
  end

  assign out_valid_o  = ser_v_q;
  assign ascii_char_o = ser_sgn_q ? CH_MINUS : (CH_ZERO + {4'd0, ser_bcd_q[ser_idx_q]});
  assign last_o       = !ser_sgn_q && (ser_idx_q == 4'd0);

  assign char_legal = (ascii_char_o == CH_MINUS) ||
                      ((ascii_char_o >= CH_ZERO) && (ascii_char_o <= CH_ZERO + 8'(DIG_MAX)));

  // Every character sent is a minus sign or a decimal digit.
  `ITDA_ASSERT(a_char_legal, !out_valid_o || char_legal)
  // The digit pointer stays inside the ten digit positions.
  `ITDA_ASSERT(a_idx_range, !ser_v_q || ser_idx_q <= DIG_MAX)
  // A minus sign is always followed by a digit of the same run.
  `ITDA_ASSERT_NEXT(a_minus_then_digit, out_fire && ascii_char_o == CH_MINUS, out_valid_o && ascii_char_o != CH_MINUS)

endmodule
